// ===== hw/rtl/agpe_pkg.sv =====
// ----------------------------------------------------------------------------
// agpe_pkg
// Shared constants, codes, types and helpers of the graph path engine.
// ----------------------------------------------------------------------------
package agpe_pkg;

  localparam int MAX_NODES  = 64;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int CNT_W      = $clog2(MAX_NODES + 1);
  localparam int MAX_DEGREE = 8;
  localparam int SLOT_W     = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int DEG_W      = $clog2(MAX_DEGREE + 1);
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int SUM_W      = 2 * COORD_BITS + 1;
  localparam int ROOT_W     = (SUM_W + 2 * FRAC_BITS + 1) / 2;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int COST_W     = 32;

  // operation codes
  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_CONNECT = 3'd1;
  localparam logic [2:0] OP_PATH    = 3'd2;
  localparam logic [2:0] OP_NEAR    = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_NOPATH = 3'd1;
  localparam logic [2:0] ST_EMPTY  = 3'd2;
  localparam logic [2:0] ST_FULL   = 3'd3;
  localparam logic [2:0] ST_BADIDX = 3'd4;

  typedef enum logic [5:0] {
    DP_NOP, DP_LOAD, DP_ADD, DP_CLEAR, DP_RD_NODE, DP_EMIT, DP_EMIT_PATH,
    DP_C_INIT, DP_C_DEG, DP_C_DEGL, DP_C_SCAN, DP_C_NEED, DP_K_INC, DP_C_SIDE,
    DP_RD_A, DP_RD_B, DP_LAT_P1, DP_LAT_P2, DP_SQ_GO, DP_C_WA, DP_C_WB,
    DP_N_INIT, DP_RD_I, DP_N_CMP, DP_P_INIT, DP_P_START, DP_I0, DP_I_INC,
    DP_RD_NS_I, DP_S_CMP, DP_RD_DEGC, DP_CLOSE, DP_RD_ADJ, DP_E_ADJ, DP_RD_NB,
    DP_E_LAT, DP_E_UPD, DP_T_INIT, DP_T_RD, DP_T_PUSH, DP_RD_STK, DP_RD_STKPOS
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] code;
    logic       node;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       full_tab;
    logic       empty;
    logic       ab_ok;
    logic       k_end;
    logic       adj_hit;
    logic       side;
    logic       a_eq_b;
    logic       need_a;
    logic       need_b;
    logic       deg_full;
    logic       sq_done;
    logic       i_end;
    logic       found;
    logic       open_i;
    logic       cur_is_b;
    logic       nb_skip;
    logic       p_stop;
    logic       from_bad;
    logic       len_one;
    logic       out_free;
  } dp_stat_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         d;
  } pos_t;

  typedef struct packed {
    logic [NODE_W-1:0] idx;
    logic [ROOT_W-1:0] len;
  } adj_t;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [COST_W-1:0] tot;
    logic [NODE_W-1:0] from;
    logic [CNT_W-1:0]  order;
  } nstate_t;

  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] p,
                                                input logic [COST_W-1:0] q);
    logic [COST_W:0] s;
    s = {1'b0, p} + {1'b0, q};
    return s[COST_W] ? {COST_W{1'b1}} : s[COST_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/agpe_sqrt.sv =====
// ----------------------------------------------------------------------------
// agpe_sqrt
// Fixed-point euclidean distance: squares, then one root bit per cycle.
// ----------------------------------------------------------------------------
module agpe_sqrt import agpe_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [COORD_BITS-1:0] x1,
  input  logic signed [COORD_BITS-1:0] y1,
  input  logic signed [COORD_BITS-1:0] x2,
  input  logic signed [COORD_BITS-1:0] y2,
  output logic                         busy,
  output logic                         done,
  output logic [ROOT_W-1:0]            root
);

  localparam logic [2:0] Q_IDLE = 3'd0;
  localparam logic [2:0] Q_DIF  = 3'd1;
  localparam logic [2:0] Q_SQA  = 3'd2;
  localparam logic [2:0] Q_SQB  = 3'd3;
  localparam logic [2:0] Q_RUN  = 3'd4;
  localparam int STEP_W = $clog2(ROOT_W);
  localparam int REM_W  = ROOT_W + 2;

  logic [2:0]        state;
  logic [DIFF_W-1:0] ax, ay;
  logic [SUM_W-1:0]  sum;
  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [STEP_W-1:0] step;
  logic signed [DIFF_W-1:0] dx, dy;
  logic [REM_W+1:0]  rem_sh, trial;
  logic [SUM_W-1:0]  sum_full;

  assign dx = DIFF_W'(x1) - DIFF_W'(x2);
  assign dy = DIFF_W'(y1) - DIFF_W'(y2);
  assign rem_sh = {rem, rad[RAD_W-1 -: 2]};
  assign trial  = (REM_W + 2)'({root, 2'b01});
  assign sum_full = sum + SUM_W'(ay * ay);
  assign busy = (state != Q_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= Q_IDLE;
      done  <= 1'b0;
    end else begin
      unique case (state)
        Q_IDLE: begin
          if (start) begin
            state <= Q_DIF;
            done  <= 1'b0;
          end
        end
        Q_DIF: begin
          ax    <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
          ay    <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
          state <= Q_SQA;
        end
        Q_SQA: begin
          sum   <= SUM_W'(ax * ax);
          state <= Q_SQB;
        end
        Q_SQB: begin
          // radicand carries the fraction bits of the root
          rad   <= RAD_W'(sum_full) << (2 * FRAC_BITS);
          rem   <= '0;
          root  <= '0;
          step  <= '0;
          state <= Q_RUN;
        end
        Q_RUN: begin
          if (rem_sh >= trial) begin
            rem  <= REM_W'(rem_sh - trial);
            root <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            rem  <= REM_W'(rem_sh);
            root <= {root[ROOT_W-2:0], 1'b0};
          end
          rad  <= rad << 2;
          step <= step + 1'b1;
          if (step == STEP_W'(ROOT_W - 1)) begin
            state <= Q_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= Q_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/agpe_datapath.sv =====
// ----------------------------------------------------------------------------
// agpe_datapath
// Node tables, adjacency store, search state, distance unit and result beat.
// ----------------------------------------------------------------------------
module agpe_datapath import agpe_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  dp_cmd_t                      cmd,
  output dp_stat_t                     stat,
  input  logic [2:0]                   operation,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  input  logic                         dest_flag,
  input  logic [NODE_W-1:0]            node_a,
  input  logic [NODE_W-1:0]            node_b,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   status,
  output logic [NODE_W-1:0]            node_index,
  output logic signed [COORD_BITS-1:0] node_x,
  output logic signed [COORD_BITS-1:0] node_y,
  output logic                         node_dest,
  output logic                         last
);

  // memories
  pos_t    pos_mem [MAX_NODES];
  logic [DEG_W-1:0] deg_mem [MAX_NODES];
  adj_t    adj_mem [MAX_NODES*MAX_DEGREE];
  nstate_t ns_mem  [MAX_NODES];
  logic [NODE_W-1:0] stk_mem [MAX_NODES];

  pos_t    pos_rd;
  logic [DEG_W-1:0] deg_rd;
  adj_t    adj_rd;
  nstate_t ns_rd;
  logic [NODE_W-1:0] stk_rd;

  // registers
  logic [2:0]              op_r;
  logic signed [COORD_BITS-1:0] qx, qy;
  logic                    qd;
  logic [NODE_W-1:0]       a, b, cur, ridx, nb, n;
  logic [CNT_W-1:0]        count, i, seq, len;
  logic [DEG_W-1:0]        k, dega, degb;
  logic                    side, need_a, need_b, found;
  logic [COST_W-1:0]       btot, bcost, cost;
  logic [CNT_W-1:0]        bord;
  logic [ROOT_W-1:0]       elen;
  pos_t                    p1, p2;
  nstate_t                 old;
  logic [MAX_NODES-1:0]    openm, closedm;

  // sqrt unit
  logic              sq_busy, sq_done;
  logic [ROOT_W-1:0] sq_res;

  agpe_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.op == DP_SQ_GO),
    .x1   (p1.x),
    .y1   (p1.y),
    .x2   (p2.x),
    .y2   (p2.y),
    .busy (sq_busy),
    .done (sq_done),
    .root (sq_res)
  );

  logic [NODE_W-1:0] src, dst;
  logic [COST_W-1:0] total, res_ext;
  logic              better, out_free;

  assign src     = side ? b : a;
  assign dst     = side ? a : b;
  assign res_ext = COST_W'(sq_res);
  assign total   = sat_add(cost, res_ext);
  assign better  = !found || (ns_rd.tot < btot) ||
                   ((ns_rd.tot == btot) && (ns_rd.order < bord));
  assign out_free = !out_valid || !out_stall;

  // memory ports
  logic              pos_we, deg_we, adj_we, ns_we, stk_we;
  logic [NODE_W-1:0] pos_wa, pos_ra, deg_wa, deg_ra, ns_wa, ns_ra, stk_wa, stk_ra;
  logic [NODE_W+SLOT_W-1:0] adj_wa, adj_ra;
  pos_t              pos_wd;
  logic [DEG_W-1:0]  deg_wd;
  adj_t              adj_wd;
  nstate_t           ns_wd;
  logic [NODE_W-1:0] stk_wd;

  always_comb begin
    pos_we = 1'b0; pos_wa = count[NODE_W-1:0]; pos_wd = '{x: qx, y: qy, d: qd};
    deg_we = 1'b0; deg_wa = count[NODE_W-1:0]; deg_wd = '0;
    adj_we = 1'b0; adj_wa = {a, dega[SLOT_W-1:0]}; adj_wd = '{idx: b, len: sq_res};
    ns_we  = 1'b0; ns_wa  = nb;
    ns_wd  = '{cost: cost, tot: total, from: cur, order: seq};
    stk_we = 1'b0; stk_wa = len[NODE_W-1:0]; stk_wd = ns_rd.from;
    pos_ra = ridx; deg_ra = src; adj_ra = {src, k[SLOT_W-1:0]}; ns_ra = nb;
    stk_ra = NODE_W'(len - 1'b1);
    unique case (cmd.op)
      DP_ADD: begin
        pos_we = 1'b1;
        deg_we = 1'b1;
      end
      DP_C_WA: begin
        adj_we = 1'b1;
        deg_we = 1'b1; deg_wa = a; deg_wd = dega + 1'b1;
      end
      DP_C_WB: begin
        adj_we = 1'b1; adj_wa = {b, degb[SLOT_W-1:0]}; adj_wd = '{idx: a, len: sq_res};
        deg_we = 1'b1; deg_wa = b; deg_wd = degb + 1'b1;
      end
      DP_RD_A:      pos_ra = a;
      DP_RD_B:      pos_ra = b;
      DP_RD_I:      pos_ra = i[NODE_W-1:0];
      DP_RD_NB:     pos_ra = nb;
      DP_RD_STKPOS: pos_ra = stk_rd;
      DP_RD_DEGC:   deg_ra = cur;
      DP_RD_ADJ:    adj_ra = {cur, k[SLOT_W-1:0]};
      DP_RD_NS_I:   ns_ra = i[NODE_W-1:0];
      DP_T_RD:      ns_ra = n;
      DP_P_START: begin
        ns_we = 1'b1; ns_wa = a;
        ns_wd = '{cost: '0, tot: res_ext, from: a, order: '0};
      end
      DP_E_UPD: begin
        ns_we = !openm[nb] || (total < old.tot);
        if (openm[nb]) ns_wd.order = old.order;
      end
      DP_T_INIT: begin
        stk_we = 1'b1; stk_wa = '0; stk_wd = b;
      end
      DP_T_PUSH: stk_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    pos_rd <= pos_mem[pos_ra];
  end

  always_ff @(posedge clk) begin
    if (deg_we) deg_mem[deg_wa] <= deg_wd;
    deg_rd <= deg_mem[deg_ra];
  end

  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_wa] <= adj_wd;
    adj_rd <= adj_mem[adj_ra];
  end

  always_ff @(posedge clk) begin
    if (ns_we) ns_mem[ns_wa] <= ns_wd;
    ns_rd <= ns_mem[ns_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_rd <= stk_mem[stk_ra];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      openm   <= '0;
      closedm <= '0;
    end else begin
      unique case (cmd.op)
        DP_ADD:    count <= count + 1'b1;
        DP_CLEAR:  count <= '0;
        DP_P_INIT: begin
          openm   <= '0;
          closedm <= '0;
        end
        DP_P_START: openm[a] <= 1'b1;
        DP_E_UPD:   openm[nb] <= 1'b1;
        DP_CLOSE: begin
          openm[cur]   <= 1'b0;
          closedm[cur] <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_LOAD: begin
        op_r <= operation;
        qx   <= coord_x;
        qy   <= coord_y;
        qd   <= dest_flag;
        a    <= node_a;
        b    <= node_b;
      end
      DP_ADD: ridx <= count[NODE_W-1:0];
      DP_C_INIT: begin
        side   <= 1'b0;
        need_a <= 1'b0;
        need_b <= 1'b0;
      end
      DP_C_DEG, DP_RD_DEGC: k <= '0;
      DP_C_DEGL: begin
        if (side) degb <= deg_rd;
        else      dega <= deg_rd;
      end
      DP_C_NEED: begin
        if (side) need_b <= 1'b1;
        else      need_a <= 1'b1;
      end
      DP_K_INC:  k <= k + 1'b1;
      DP_C_SIDE: side <= 1'b1;
      DP_LAT_P1: p1 <= pos_rd;
      DP_LAT_P2: p2 <= pos_rd;
      DP_N_INIT: begin
        i     <= '0;
        found <= 1'b0;
        p2    <= '{x: qx, y: qy, d: 1'b0};
      end
      DP_N_CMP: begin
        if (!found || res_ext < btot) begin
          ridx <= i[NODE_W-1:0];
          btot <= res_ext;
        end
        found <= 1'b1;
        i     <= i + 1'b1;
      end
      DP_P_INIT: begin
        side <= 1'b0;
        seq  <= '0;
      end
      DP_P_START: seq <= CNT_W'(1);
      DP_I0: begin
        i     <= '0;
        found <= 1'b0;
      end
      DP_I_INC: i <= i + 1'b1;
      DP_S_CMP: begin
        if (better) begin
          cur   <= i[NODE_W-1:0];
          btot  <= ns_rd.tot;
          bord  <= ns_rd.order;
          bcost <= ns_rd.cost;
        end
        found <= 1'b1;
        i     <= i + 1'b1;
      end
      DP_E_ADJ: begin
        nb   <= adj_rd.idx;
        elen <= adj_rd.len;
      end
      DP_E_LAT: begin
        p1   <= pos_rd;
        old  <= ns_rd;
        cost <= sat_add(bcost, COST_W'(elen));
      end
      DP_E_UPD: begin
        if (!openm[nb]) seq <= seq + 1'b1;
        k <= k + 1'b1;
      end
      DP_T_INIT: begin
        n   <= b;
        len <= CNT_W'(1);
      end
      DP_T_PUSH: begin
        n   <= ns_rd.from;
        len <= len + 1'b1;
      end
      DP_RD_STKPOS: ridx <= stk_rd;
      DP_EMIT_PATH: len <= len - 1'b1;
      default: ;
    endcase
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == DP_EMIT || cmd.op == DP_EMIT_PATH) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_EMIT || cmd.op == DP_EMIT_PATH) begin
      status     <= cmd.code;
      last       <= cmd.last;
      node_index <= cmd.node ? ridx     : '0;
      node_x     <= cmd.node ? pos_rd.x : '0;
      node_y     <= cmd.node ? pos_rd.y : '0;
      node_dest  <= cmd.node ? pos_rd.d : 1'b0;
    end
  end

  // status to the controller
  always_comb begin
    stat.op       = op_r;
    stat.full_tab = (count == CNT_W'(MAX_NODES));
    stat.empty    = (count == '0);
    stat.ab_ok    = ({1'b0, a} < count) && ({1'b0, b} < count);
    stat.k_end    = (k == (side ? degb : dega));
    stat.adj_hit  = (adj_rd.idx == dst);
    stat.side     = side;
    stat.a_eq_b   = (a == b);
    stat.need_a   = need_a;
    stat.need_b   = need_b;
    stat.deg_full = (need_a && dega == DEG_W'(MAX_DEGREE)) ||
                    (need_b && degb == DEG_W'(MAX_DEGREE));
    stat.sq_done  = sq_done;
    stat.i_end    = (i == count);
    stat.found    = found;
    stat.open_i   = openm[i[NODE_W-1:0]];
    stat.cur_is_b = (cur == b);
    stat.nb_skip  = ({1'b0, nb} >= count) || closedm[nb];
    stat.p_stop   = (n == a) || (len == count);
    stat.from_bad = ({1'b0, ns_rd.from} >= count);
    stat.len_one  = (len == CNT_W'(1));
    stat.out_free = out_free;
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_EMIT || cmd.op == DP_EMIT_PATH) |-> out_free)
    else $error("result loaded over an unaccepted beat");

  a_sqrt_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_SQ_GO) |-> !sq_busy)
    else $error("distance unit started while busy");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_NODES))
    else $error("node count out of range");

  a_edge_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_C_WA) |-> (dega < DEG_W'(MAX_DEGREE)))
    else $error("edge written past degree limit");

endmodule

// ===== hw/rtl/agpe_ctrl.sv =====
// ----------------------------------------------------------------------------
// agpe_ctrl
// Sequencer for add, connect, nearest, search, path trace and clear.
// ----------------------------------------------------------------------------
module agpe_ctrl import agpe_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [5:0] S_IDLE     = 6'd0;
  localparam logic [5:0] S_DEC      = 6'd1;
  localparam logic [5:0] S_EMIT_ST  = 6'd2;
  localparam logic [5:0] S_RDNODE   = 6'd3;
  localparam logic [5:0] S_EMITNODE = 6'd4;
  localparam logic [5:0] S_C_DEG    = 6'd5;
  localparam logic [5:0] S_C_DEGL   = 6'd6;
  localparam logic [5:0] S_C_SCAN   = 6'd7;
  localparam logic [5:0] S_C_CHK    = 6'd8;
  localparam logic [5:0] S_C_SIDE   = 6'd9;
  localparam logic [5:0] S_C_FULL   = 6'd10;
  localparam logic [5:0] S_C_LA     = 6'd11;
  localparam logic [5:0] S_C_RDB    = 6'd12;
  localparam logic [5:0] S_C_LB     = 6'd13;
  localparam logic [5:0] S_C_GO     = 6'd14;
  localparam logic [5:0] S_C_WAIT   = 6'd15;
  localparam logic [5:0] S_C_WA     = 6'd16;
  localparam logic [5:0] S_C_WB     = 6'd17;
  localparam logic [5:0] S_N_RD     = 6'd18;
  localparam logic [5:0] S_N_LAT    = 6'd19;
  localparam logic [5:0] S_N_GO     = 6'd20;
  localparam logic [5:0] S_N_WAIT   = 6'd21;
  localparam logic [5:0] S_N_CMP    = 6'd22;
  localparam logic [5:0] S_P_RDB    = 6'd23;
  localparam logic [5:0] S_P_LB     = 6'd24;
  localparam logic [5:0] S_P_RDA    = 6'd25;
  localparam logic [5:0] S_P_LA     = 6'd26;
  localparam logic [5:0] S_P_GO     = 6'd27;
  localparam logic [5:0] S_P_WAIT   = 6'd28;
  localparam logic [5:0] S_P_START  = 6'd29;
  localparam logic [5:0] S_SEL0     = 6'd30;
  localparam logic [5:0] S_SEL      = 6'd31;
  localparam logic [5:0] S_SEL_CMP  = 6'd32;
  localparam logic [5:0] S_X_DEG    = 6'd33;
  localparam logic [5:0] S_X_DEGL   = 6'd34;
  localparam logic [5:0] S_X_K      = 6'd35;
  localparam logic [5:0] S_X_ADJ    = 6'd36;
  localparam logic [5:0] S_X_CHK    = 6'd37;
  localparam logic [5:0] S_X_LAT    = 6'd38;
  localparam logic [5:0] S_X_GO     = 6'd39;
  localparam logic [5:0] S_X_WAIT   = 6'd40;
  localparam logic [5:0] S_X_UPD    = 6'd41;
  localparam logic [5:0] S_T_INIT   = 6'd42;
  localparam logic [5:0] S_T_LOOP   = 6'd43;
  localparam logic [5:0] S_T_STEP   = 6'd44;
  localparam logic [5:0] S_T_ES     = 6'd45;
  localparam logic [5:0] S_T_EP     = 6'd46;
  localparam logic [5:0] S_T_EM     = 6'd47;

  logic [5:0] state, state_next;
  logic [2:0] code, code_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= ST_OK;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  always_comb begin
    state_next = state;
    code_next  = code;
    cmd        = '{op: DP_NOP, code: ST_OK, node: 1'b0, last: 1'b1};
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = DP_LOAD;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        unique case (stat.op)
          OP_ADD: begin
            if (stat.full_tab) begin
              code_next  = ST_FULL;
              state_next = S_EMIT_ST;
            end else begin
              cmd.op     = DP_ADD;
              state_next = S_RDNODE;
            end
          end
          OP_CONNECT: begin
            if (!stat.ab_ok) begin
              code_next  = ST_BADIDX;
              state_next = S_EMIT_ST;
            end else begin
              cmd.op     = DP_C_INIT;
              state_next = S_C_DEG;
            end
          end
          OP_PATH: begin
            if (stat.empty) begin
              code_next  = ST_EMPTY;
              state_next = S_EMIT_ST;
            end else if (!stat.ab_ok) begin
              code_next  = ST_BADIDX;
              state_next = S_EMIT_ST;
            end else begin
              cmd.op     = DP_P_INIT;
              state_next = S_P_RDB;
            end
          end
          OP_NEAR: begin
            if (stat.empty) begin
              code_next  = ST_EMPTY;
              state_next = S_EMIT_ST;
            end else begin
              cmd.op     = DP_N_INIT;
              state_next = S_N_RD;
            end
          end
          OP_CLEAR: begin
            cmd.op     = DP_CLEAR;
            code_next  = ST_OK;
            state_next = S_EMIT_ST;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_EMIT_ST: begin
        if (stat.out_free) begin
          cmd.op     = DP_EMIT;
          cmd.code   = code;
          state_next = S_IDLE;
        end
      end
      S_RDNODE: begin
        cmd.op     = DP_RD_NODE;
        state_next = S_EMITNODE;
      end
      S_EMITNODE: begin
        if (stat.out_free) begin
          cmd.op     = DP_EMIT;
          cmd.node   = 1'b1;
          state_next = S_IDLE;
        end
      end
      // connect: look for the edge on each side, then length and writes
      S_C_DEG: begin
        cmd.op     = DP_C_DEG;
        state_next = S_C_DEGL;
      end
      S_C_DEGL: begin
        cmd.op     = DP_C_DEGL;
        state_next = S_C_SCAN;
      end
      S_C_SCAN: begin
        if (stat.k_end) begin
          cmd.op     = DP_C_NEED;
          state_next = S_C_SIDE;
        end else begin
          cmd.op     = DP_C_SCAN;
          state_next = S_C_CHK;
        end
      end
      S_C_CHK: begin
        if (stat.adj_hit) begin
          state_next = S_C_SIDE;
        end else begin
          cmd.op     = DP_K_INC;
          state_next = S_C_SCAN;
        end
      end
      S_C_SIDE: begin
        if (stat.side || stat.a_eq_b) begin
          state_next = S_C_FULL;
        end else begin
          cmd.op     = DP_C_SIDE;
          state_next = S_C_DEG;
        end
      end
      S_C_FULL: begin
        if (stat.deg_full) begin
          code_next  = ST_FULL;
          state_next = S_EMIT_ST;
        end else begin
          cmd.op     = DP_RD_A;
          state_next = S_C_LA;
        end
      end
      S_C_LA: begin
        cmd.op     = DP_LAT_P1;
        state_next = S_C_RDB;
      end
      S_C_RDB: begin
        cmd.op     = DP_RD_B;
        state_next = S_C_LB;
      end
      S_C_LB: begin
        cmd.op     = DP_LAT_P2;
        state_next = S_C_GO;
      end
      S_C_GO: begin
        cmd.op     = DP_SQ_GO;
        state_next = S_C_WAIT;
      end
      S_C_WAIT: begin
        if (stat.sq_done) state_next = S_C_WA;
      end
      S_C_WA: begin
        if (stat.need_a) cmd.op = DP_C_WA;
        state_next = S_C_WB;
      end
      S_C_WB: begin
        if (stat.need_b) cmd.op = DP_C_WB;
        code_next  = ST_OK;
        state_next = S_EMIT_ST;
      end
      // nearest node: one distance per stored node
      S_N_RD: begin
        if (stat.i_end) begin
          cmd.op     = DP_RD_NODE;
          state_next = S_EMITNODE;
        end else begin
          cmd.op     = DP_RD_I;
          state_next = S_N_LAT;
        end
      end
      S_N_LAT: begin
        cmd.op     = DP_LAT_P1;
        state_next = S_N_GO;
      end
      S_N_GO: begin
        cmd.op     = DP_SQ_GO;
        state_next = S_N_WAIT;
      end
      S_N_WAIT: begin
        if (stat.sq_done) state_next = S_N_CMP;
      end
      S_N_CMP: begin
        cmd.op     = DP_N_CMP;
        state_next = S_N_RD;
      end
      // search: seed start node with heuristic
      S_P_RDB: begin
        cmd.op     = DP_RD_B;
        state_next = S_P_LB;
      end
      S_P_LB: begin
        cmd.op     = DP_LAT_P2;
        state_next = S_P_RDA;
      end
      S_P_RDA: begin
        cmd.op     = DP_RD_A;
        state_next = S_P_LA;
      end
      S_P_LA: begin
        cmd.op     = DP_LAT_P1;
        state_next = S_P_GO;
      end
      S_P_GO: begin
        cmd.op     = DP_SQ_GO;
        state_next = S_P_WAIT;
      end
      S_P_WAIT: begin
        if (stat.sq_done) state_next = S_P_START;
      end
      S_P_START: begin
        cmd.op     = DP_P_START;
        state_next = S_SEL0;
      end
      // pick the best open node by a linear sweep
      S_SEL0: begin
        cmd.op     = DP_I0;
        state_next = S_SEL;
      end
      S_SEL: begin
        if (stat.i_end) begin
          if (!stat.found) begin
            code_next  = ST_NOPATH;
            state_next = S_EMIT_ST;
          end else if (stat.cur_is_b) begin
            state_next = S_T_INIT;
          end else begin
            state_next = S_X_DEG;
          end
        end else if (!stat.open_i) begin
          cmd.op = DP_I_INC;
        end else begin
          cmd.op     = DP_RD_NS_I;
          state_next = S_SEL_CMP;
        end
      end
      S_SEL_CMP: begin
        cmd.op     = DP_S_CMP;
        state_next = S_SEL;
      end
      // expand the chosen node over its neighbours
      S_X_DEG: begin
        cmd.op     = DP_RD_DEGC;
        state_next = S_X_DEGL;
      end
      S_X_DEGL: begin
        cmd.op     = DP_C_DEGL;
        state_next = S_X_K;
      end
      S_X_K: begin
        if (stat.k_end) begin
          cmd.op     = DP_CLOSE;
          state_next = S_SEL0;
        end else begin
          cmd.op     = DP_RD_ADJ;
          state_next = S_X_ADJ;
        end
      end
      S_X_ADJ: begin
        cmd.op     = DP_E_ADJ;
        state_next = S_X_CHK;
      end
      S_X_CHK: begin
        if (stat.nb_skip) begin
          cmd.op     = DP_K_INC;
          state_next = S_X_K;
        end else begin
          cmd.op     = DP_RD_NB;
          state_next = S_X_LAT;
        end
      end
      S_X_LAT: begin
        cmd.op     = DP_E_LAT;
        state_next = S_X_GO;
      end
      S_X_GO: begin
        cmd.op     = DP_SQ_GO;
        state_next = S_X_WAIT;
      end
      S_X_WAIT: begin
        if (stat.sq_done) state_next = S_X_UPD;
      end
      S_X_UPD: begin
        cmd.op     = DP_E_UPD;
        state_next = S_X_K;
      end
      // walk back from the finish, then send the stack in reverse
      S_T_INIT: begin
        cmd.op     = DP_T_INIT;
        state_next = S_T_LOOP;
      end
      S_T_LOOP: begin
        if (stat.p_stop) begin
          state_next = S_T_ES;
        end else begin
          cmd.op     = DP_T_RD;
          state_next = S_T_STEP;
        end
      end
      S_T_STEP: begin
        if (stat.from_bad) begin
          state_next = S_T_ES;
        end else begin
          cmd.op     = DP_T_PUSH;
          state_next = S_T_LOOP;
        end
      end
      S_T_ES: begin
        cmd.op     = DP_RD_STK;
        state_next = S_T_EP;
      end
      S_T_EP: begin
        cmd.op     = DP_RD_STKPOS;
        state_next = S_T_EM;
      end
      S_T_EM: begin
        if (stat.out_free) begin
          cmd.op     = DP_EMIT_PATH;
          cmd.node   = 1'b1;
          cmd.last   = stat.len_one;
          state_next = stat.len_one ? S_IDLE : S_T_ES;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/astar_graph_path_engine.sv =====
// ----------------------------------------------------------------------------
// astar_graph_path_engine
// Node table with undirected edges, nearest-node query and A* path search.
//
//   channel  handshake          payload
//   input    in_valid/in_stall  operation coord_x coord_y dest_flag node_a node_b
//   output   out_valid/out_stall status node_index node_x node_y node_dest last
//
// One item at a time. Each distance runs in the shared bit-serial root
// unit; nearest takes one distance per stored node, and each search
// expansion sweeps the nodes, then takes one distance per relaxed edge.
// A path is sent beat by beat; out_stall holds the sequencer.
// Synchronous reset clears node count and control; tables need no clearing.
// ----------------------------------------------------------------------------
module astar_graph_path_engine import agpe_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   operation,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  input  logic                         dest_flag,
  input  logic [NODE_W-1:0]            node_a,
  input  logic [NODE_W-1:0]            node_b,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   status,
  output logic [NODE_W-1:0]            node_index,
  output logic signed [COORD_BITS-1:0] node_x,
  output logic signed [COORD_BITS-1:0] node_y,
  output logic                         node_dest,
  output logic                         last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  agpe_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  agpe_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .operation (operation),
    .coord_x   (coord_x),
    .coord_y   (coord_y),
    .dest_flag (dest_flag),
    .node_a    (node_a),
    .node_b    (node_b),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .node_index(node_index),
    .node_x    (node_x),
    .node_y    (node_y),
    .node_dest (node_dest),
    .last      (last)
  );

endmodule
